FILE: rtl/core/dfs_pkg.sv
// shared types, constants and helper functions of the delimited field byte selector
`default_nettype none

package dfs_pkg;

   // sizing of the first-field store and the selection mask
   localparam int FIRST_FIELD_DEPTH = 32;
   localparam int MASK_POSITIONS    = 64;
   localparam int MASK_W            = 64;
   localparam int MASK_IDX_W        = $clog2(MASK_W);
   localparam int FF_ADDR_W         = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;
   localparam int FF_FILL_W         = $clog2(FIRST_FIELD_DEPTH + 1);
   localparam int COUNT_W           = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;

   // character codes
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] TAB_BYTE     = 8'd9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_DELIMITER  = 3'd1,
      CSR_MASK       = 3'd2,
      CSR_OPEN_FROM  = 3'd3,
      CSR_SUPPRESS   = 3'd4
   } csr_index_type;

   // selection modes
   localparam logic MODE_BYTES  = 1'b0;
   localparam logic MODE_FIELDS = 1'b1;

   // configuration seen by the datapath
   typedef struct packed {
      logic                 mode;
      logic [7:0]           delimiter;
      logic [MASK_W-1:0]    select_mask;
      logic [COUNT_W-1:0]   open_from;
      logic                 suppress_undelimited;
   } cfg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN_RD,
      ST_DRAIN_WR,
      ST_TAIL
   } dfs_state_type;

   // saturating increment of a line counter
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

   // is position or field n selected by mask or open range
   function automatic logic is_selected(input logic [COUNT_W-1:0] n,
                                        input cfg_type cfg);
      logic [COUNT_W-1:0]    nm1;
      logic                  in_mask;
      nm1 = n - COUNT_W'(1);
      in_mask = (n >= COUNT_W'(1)) && (n <= COUNT_W'(MASK_POSITIONS)) &&
                cfg.select_mask[nm1[MASK_IDX_W-1:0]];
      is_selected = in_mask || ((cfg.open_from != '0) && (n >= cfg.open_from));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dfs_store.sv
// first-field store: one write port, one registered read port
`default_nettype none

module dfs_store
   import dfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [FF_ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]           wr_data,
   input  wire logic                 rd_en,
   input  wire logic [FF_ADDR_W-1:0] rd_addr,
   output      logic [7:0]           rd_data
);

   logic [7:0] mem [FIRST_FIELD_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dfs_csr.sv
// configuration registers of the delimited field byte selector
`default_nettype none

module dfs_csr
   import dfs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:      cfg_in.mode                 = csr_data[0];
            CSR_DELIMITER: cfg_in.delimiter            = csr_data[7:0];
            CSR_MASK:      cfg_in.select_mask          = csr_data[MASK_W-1:0];
            CSR_OPEN_FROM: cfg_in.open_from            = csr_data[COUNT_W-1:0];
            CSR_SUPPRESS:  cfg_in.suppress_undelimited = csr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode                 <= MODE_BYTES;
         cfg_ff.delimiter            <= TAB_BYTE;
         cfg_ff.select_mask          <= '0;
         cfg_ff.open_from            <= '0;
         cfg_ff.suppress_undelimited <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dfs_ctrl.sv
// line state, store sequencer and output register
`default_nettype none

module dfs_ctrl
   import dfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tuser,
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [7:0]           rsp_tdata,
   output      logic                 rsp_tlast,
   output      logic                 rsp_tuser,
   output      logic                 st_wr_en,
   output      logic [FF_ADDR_W-1:0] st_wr_addr,
   output      logic [7:0]           st_wr_data,
   output      logic                 st_rd_en,
   output      logic [FF_ADDR_W-1:0] st_rd_addr,
   input  wire logic [7:0]           st_rd_data
);

   dfs_state_type state_ff, state_in;

   // line state
   logic [COUNT_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0]   fc_ff, fc_in;
   logic                 dseen_ff, dseen_in;
   logic                 femit_ff, femit_in;
   logic                 pending_ff, pending_in;
   logic [FF_FILL_W-1:0] fill_ff, fill_in;
   logic                 ovf_ff, ovf_in;

   // drain sequence
   logic [FF_FILL_W-1:0] didx_ff, didx_in;
   logic [FF_FILL_W-1:0] dcnt_ff, dcnt_in;
   logic                 tail_ff, tail_in;
   logic [7:0]           tail_byte_ff, tail_byte_in;
   logic                 sovf_ff, sovf_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff;
   logic                 out_last_ff;
   logic                 out_ovf_ff;
   logic                 load;
   logic [7:0]           load_byte;
   logic                 load_last;
   logic                 load_ovf;

   logic                 out_free;
   logic                 accept;
   logic [COUNT_W-1:0]   pos_inc;
   logic [COUNT_W-1:0]   fc_inc;
   logic                 is_delim;
   logic                 sel_one;
   logic                 sel_fc;
   logic                 sel_fc_inc;
   logic                 femit_mid;
   logic [FF_FILL_W-1:0] didx_next;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign pos_inc    = sat_inc(pos_ff);
   assign fc_inc     = sat_inc(fc_ff);
   assign is_delim   = (req_tdata == cfg.delimiter);
   assign sel_one    = is_selected(COUNT_W'(1), cfg);
   assign sel_fc     = is_selected(fc_ff, cfg);
   assign sel_fc_inc = is_selected(fc_inc, cfg);
   assign femit_mid  = femit_ff || (!dseen_ff && sel_one);
   assign didx_next  = didx_ff + FF_FILL_W'(1);

   assign st_wr_addr = fill_ff[FF_ADDR_W-1:0];
   assign st_wr_data = req_tdata;
   assign st_rd_addr = didx_ff[FF_ADDR_W-1:0];

   // next state, line update and output loading
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      fc_in        = fc_ff;
      dseen_in     = dseen_ff;
      femit_in     = femit_ff;
      pending_in   = pending_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      didx_in      = didx_ff;
      dcnt_in      = dcnt_ff;
      tail_in      = tail_ff;
      tail_byte_in = tail_byte_ff;
      sovf_in      = sovf_ff;
      load         = 1'b0;
      load_byte    = req_tdata;
      load_last    = 1'b1;
      load_ovf     = ovf_ff;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser || req_tdata == NEWLINE_BYTE) begin
                  // end of line, unless end of source finds nothing pending
                  if (!(req_tuser && !pending_ff)) begin
                     if (cfg.mode == MODE_BYTES || dseen_ff) begin
                        load      = 1'b1;
                        load_byte = NEWLINE_BYTE;
                     end else if (!cfg.suppress_undelimited) begin
                        if (fill_ff != '0) begin
                           didx_in      = '0;
                           dcnt_in      = fill_ff;
                           tail_in      = 1'b1;
                           tail_byte_in = NEWLINE_BYTE;
                           sovf_in      = ovf_ff;
                           state_in     = ST_DRAIN_RD;
                        end else begin
                           load      = 1'b1;
                           load_byte = NEWLINE_BYTE;
                        end
                     end
                  end
                  pos_in     = '0;
                  fc_in      = COUNT_W'(1);
                  dseen_in   = 1'b0;
                  femit_in   = 1'b0;
                  pending_in = 1'b0;
                  fill_in    = '0;
                  ovf_in     = 1'b0;
               end else if (cfg.mode == MODE_BYTES) begin
                  // byte positions
                  pending_in = 1'b1;
                  pos_in     = pos_inc;
                  load       = is_selected(pos_inc, cfg);
               end else if (is_delim) begin
                  // delimiter: first one may release the held first field
                  pending_in = 1'b1;
                  dseen_in   = 1'b1;
                  fc_in      = fc_inc;
                  femit_in   = femit_mid || sel_fc_inc;
                  if (!dseen_ff && sel_one && fill_ff != '0) begin
                     didx_in      = '0;
                     dcnt_in      = fill_ff;
                     tail_in      = sel_fc_inc && femit_mid;
                     tail_byte_in = req_tdata;
                     sovf_in      = ovf_ff;
                     state_in     = ST_DRAIN_RD;
                  end else begin
                     load = sel_fc_inc && femit_mid;
                  end
               end else if (!dseen_ff) begin
                  // hold first field bytes, drop the excess
                  pending_in = 1'b1;
                  if (fill_ff < FF_FILL_W'(FIRST_FIELD_DEPTH)) begin
                     st_wr_en = 1'b1;
                     fill_in  = fill_ff + FF_FILL_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  pending_in = 1'b1;
                  load       = sel_fc;
               end
            end
         end

         ST_DRAIN_RD: begin
            st_rd_en = 1'b1;
            state_in = ST_DRAIN_WR;
         end

         ST_DRAIN_WR: begin
            load_byte = st_rd_data;
            load_ovf  = sovf_ff;
            load_last = (didx_next == dcnt_ff) && !tail_ff;
            if (out_free) begin
               load    = 1'b1;
               didx_in = didx_next;
               if (didx_next == dcnt_ff) begin
                  state_in = tail_ff ? ST_TAIL : ST_IDLE;
               end else begin
                  state_in = ST_DRAIN_RD;
               end
            end
         end

         ST_TAIL: begin
            load_byte = tail_byte_ff;
            load_ovf  = sovf_ff;
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      out_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         fc_ff        <= COUNT_W'(1);
         dseen_ff     <= 1'b0;
         femit_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fc_ff        <= fc_in;
         dseen_ff     <= dseen_in;
         femit_ff     <= femit_in;
         pending_ff   <= pending_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      didx_ff      <= didx_in;
      dcnt_ff      <= dcnt_in;
      tail_ff      <= tail_in;
      tail_byte_ff <= tail_byte_in;
      sovf_ff      <= sovf_in;
      if (load) begin
         out_byte_ff <= load_byte;
         out_last_ff <= load_last;
         out_ovf_ff  <= load_ovf;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

`default_nettype wire

FILE: rtl/core/delimited_field_byte_selector.sv
// Selects bytes or delimiter separated fields from each newline terminated line of a text
// stream. Ordinary bytes are taken one per cycle whenever the output register is free. In
// field mode the first field of a line is held in a 32 byte store until the first delimiter
// or the line end. Releasing it reads each held byte through the single registered read
// port of that store into the one output register, then sends a trailing delimiter or
// newline where due. No input item is taken while such a release runs or while a result
// waits unclaimed. No clearing pass follows reset.
`default_nettype none

module delimited_field_byte_selector
   import dfs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input items
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] in_byte
   input  wire logic                   req_tuser,   // [0] end_of_source
   // result items
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [7:0]             rsp_tdata,   // [7:0] out_byte
   output      logic                   rsp_tlast,
   output      logic                   rsp_tuser,   // [0] overflow
   // configuration writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type              cfg;
   logic                 st_wr_en;
   logic [FF_ADDR_W-1:0] st_wr_addr;
   logic [7:0]           st_wr_data;
   logic                 st_rd_en;
   logic [FF_ADDR_W-1:0] st_rd_addr;
   logic [7:0]           st_rd_data;

   // configuration registers
   dfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // line control and output
   dfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .st_wr_en   (st_wr_en),
      .st_wr_addr (st_wr_addr),
      .st_wr_data (st_wr_data),
      .st_rd_en   (st_rd_en),
      .st_rd_addr (st_rd_addr),
      .st_rd_data (st_rd_data)
   );

   // first field store
   dfs_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/core/dfs_checker.sv
// port level checks of the delimited field byte selector and their binding
`default_nettype none

module dfs_checker
   import dfs_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // no input item is taken while a result is stalled
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   // while a run of results is still going no new input item is taken
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !(req_tvalid && req_tready))
      else $error("input taken inside a run of results");

endmodule

bind delimited_field_byte_selector dfs_checker u_dfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: test/testbench.sv
// testbench of the delimited field byte selector: directed and random lines, built-in predictor
`default_nettype none

module testbench;
   import dfs_pkg::*;

   localparam int         DRAIN_CYCLES = 80;
   localparam int         STALL_LIMIT  = 2000;
   localparam logic [7:0] COMMA_BYTE   = 8'h2C;

   typedef struct {
      logic [7:0] text;
      logic       tail;
      logic       ovf;
   } text_item_type;

   typedef enum int {
      IDLING_SENDER_LIGHT,
      IDLING_SENDER_HEAVY,
      IDLING_NONE
   } idling_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] in_byte
   logic                   req_tuser;   // [0] end_of_source
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [7:0] out_byte
   logic                   rsp_tlast;
   logic                   rsp_tuser;   // [0] overflow
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   delimited_field_byte_selector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // selector settings as last written
   logic                 sel_mode;
   logic [7:0]           sel_delim;
   logic [63:0]          sel_mask;
   logic [15:0]          sel_open;
   logic                 sel_suppress;

   // line state of the predictor
   logic [15:0]          line_pos;
   logic [15:0]          line_field;
   logic                 saw_delim;
   logic                 field_out;
   logic                 line_open;
   logic [7:0]           head_buf [FIRST_FIELD_DEPTH];
   int                   head_len;
   logic                 head_ovf;

   text_item_type        expected_text [$];
   int                   failures;
   int                   items_sent;
   int                   stall_cycles;
   int                   tx_idle_pct;
   int                   rx_idle_pct;

   // position or field n picked by mask or open range
   function automatic bit picked(int n);
      if (n >= 1 && n <= MASK_POSITIONS && sel_mask[n-1])
         return 1'b1;
      return (sel_open != 16'd0) && (n >= int'(sel_open));
   endfunction

   function automatic void emit_text(logic [7:0] b);
      expected_text.push_back('{text: b, tail: 1'b0, ovf: head_ovf});
   endfunction

   function automatic void clear_line_state();
      line_pos   = 16'd0;
      line_field = 16'd1;
      saw_delim  = 1'b0;
      field_out  = 1'b0;
      line_open  = 1'b0;
      head_len   = 0;
      head_ovf   = 1'b0;
   endfunction

   // end of line: newline, after the held first field when no delimiter came, nothing if suppressed
   function automatic void close_line();
      if (sel_mode == MODE_BYTES || saw_delim) begin
         emit_text(NEWLINE_BYTE);
      end else if (!sel_suppress) begin
         for (int i = 0; i < head_len; i++)
            emit_text(head_buf[i]);
         emit_text(NEWLINE_BYTE);
      end
      clear_line_state();
   endfunction

   function automatic void take_text_byte(logic [7:0] b);
      line_open = 1'b1;
      // byte mode: position select
      if (sel_mode == MODE_BYTES) begin
         if (line_pos != COUNT_MAX)
            line_pos = line_pos + 16'd1;
         if (picked(int'(line_pos)))
            emit_text(b);
         return;
      end
      // field mode: delimiter releases the first field and joins selected fields
      if (b == sel_delim) begin
         if (!saw_delim) begin
            saw_delim = 1'b1;
            if (picked(1)) begin
               for (int i = 0; i < head_len; i++)
                  emit_text(head_buf[i]);
               field_out = 1'b1;
            end
         end
         if (line_field != COUNT_MAX)
            line_field = line_field + 16'd1;
         if (picked(int'(line_field))) begin
            if (field_out)
               emit_text(b);
            field_out = 1'b1;
         end
         return;
      end
      // first field is held until its fate is known
      if (!saw_delim) begin
         if (head_len < FIRST_FIELD_DEPTH) begin
            head_buf[head_len] = b;
            head_len++;
         end else begin
            head_ovf = 1'b1;
         end
         return;
      end
      if (picked(int'(line_field)))
         emit_text(b);
   endfunction

   // expected output text of one accepted item
   function automatic void predict_cut(logic [7:0] b, logic eos);
      int            prior_size;
      text_item_type last_one;
      prior_size = expected_text.size();
      if (eos) begin
         if (line_open)
            close_line();
         else
            clear_line_state();
      end else if (b == NEWLINE_BYTE) begin
         close_line();
      end else begin
         take_text_byte(b);
      end
      if (expected_text.size() > prior_size) begin
         last_one = expected_text.pop_back();
         last_one.tail = 1'b1;
         expected_text.push_back(last_one);
      end
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // prediction on accepted items, checking of accepted results
   always @(posedge clock) begin : monitor
      text_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_cut(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected result: out_byte %02h", rsp_tdata);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.text) begin
                  $error("out_byte mismatch: expected %02h, got %02h", want.text, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.tail) begin
                  $error("last_of_run mismatch: expected %0b, got %0b", want.tail, rsp_tlast);
                  failures++;
               end
               if (rsp_tuser !== want.ovf) begin
                  $error("overflow mismatch: expected %0b, got %0b", want.ovf, rsp_tuser);
                  failures++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      do
         @(posedge clock);
      while (stall_cycles < STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic set_idling(idling_type regime);
      case (regime)
         IDLING_SENDER_LIGHT: begin
            tx_idle_pct = 37;
            rx_idle_pct = 71;
         end
         IDLING_SENDER_HEAVY: begin
            tx_idle_pct = 71;
            rx_idle_pct = 37;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   // one input item, with random idle cycles ahead of it
   task automatic send_item(logic [7:0] b, logic eos);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eos;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   // wait until every expected item has come and the block has gone quiet
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_MODE:      sel_mode     = value[0];
         CSR_DELIMITER: sel_delim    = value[7:0];
         CSR_MASK:      sel_mask     = value;
         CSR_OPEN_FROM: sel_open     = value[15:0];
         CSR_SUPPRESS:  sel_suppress = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [63:0] mode, logic [63:0] delim, logic [63:0] mask,
                            logic [63:0] open_from, logic [63:0] suppress);
      quiesce();
      write_reg(CSR_MODE, mode);
      write_reg(CSR_DELIMITER, delim);
      write_reg(CSR_MASK, mask);
      write_reg(CSR_OPEN_FROM, open_from);
      write_reg(CSR_SUPPRESS, suppress);
   endtask

   // byte extremes and positions 1 and 3 of a mask that also selects position 64
   task automatic test_byte_positions();
      configure(64'(MODE_BYTES), 64'(TAB_BYTE), 64'h8000_0000_0000_0005, 64'd0, 64'd0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h41, 1'b0);
      send_text("\n");
   endtask

   // fields one and three joined by the delimiter
   task automatic test_field_join();
      configure(64'(MODE_FIELDS), 64'(TAB_BYTE), 64'h5, 64'd0, 64'd0);
      send_text("a\tb\tc\n");
   endtask

   // newline still ends the line when it is also the delimiter
   task automatic test_newline_delimiter();
      configure(64'(MODE_FIELDS), 64'(NEWLINE_BYTE), '1, 64'd0, 64'd0);
      send_text("xy\n");
   endtask

   // undelimited line dropped, then end of source with nothing pending
   task automatic test_suppressed_line();
      configure(64'(MODE_FIELDS), 64'(COMMA_BYTE), '1, 64'd0, 64'd1);
      send_text("ab\n");
      send_item(8'hFF, 1'b1);
      send_text("c,d\n");
   endtask

   // first field longer than the store, then released by a zero delimiter
   task automatic test_long_first_field();
      configure(64'(MODE_FIELDS), 64'h00, '1, 64'hFFFF, 64'd0);
      for (int i = 0; i < FIRST_FIELD_DEPTH + 4; i++)
         send_item(8'h41 + 8'(i % 26), 1'b0);
      send_item(8'h00, 1'b0);
      send_text("\n");
   endtask

   // mode switched between two halves of one line, flushed by end of source
   task automatic test_mode_change();
      configure(64'(MODE_FIELDS), 64'(TAB_BYTE), '1, 64'd0, 64'd0);
      send_text("pq");
      quiesce();
      write_reg(CSR_MODE, 64'(MODE_BYTES));
      send_text("r");
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // random settings, narrow registers carrying random upper bits
   task automatic random_configure();
      logic [63:0] junk;
      logic [63:0] mode_v, delim_v, mask_v, open_v, supp_v;
      junk = {$urandom, $urandom};
      mode_v = {junk[63:1], 1'($urandom_range(0, 1))};
      junk = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0:       delim_v = {junk[63:8], TAB_BYTE};
         1:       delim_v = {junk[63:8], COMMA_BYTE};
         2:       delim_v = {junk[63:8], 8'h00};
         3:       delim_v = {junk[63:8], 8'hFF};
         default: delim_v = junk;
      endcase
      case ($urandom_range(0, 3))
         0:       mask_v = {$urandom, $urandom};
         1:       mask_v = 64'($urandom_range(0, 255));
         2:       mask_v = '1;
         default: mask_v = 64'($urandom_range(1, 15));
      endcase
      junk = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0, 1:    open_v = {junk[63:16], 16'd0};
         2:       open_v = {junk[63:16], 16'($urandom_range(1, 6))};
         default: open_v = junk;
      endcase
      junk = {$urandom, $urandom};
      supp_v = {junk[63:1], 1'($urandom_range(0, 1))};
      configure(mode_v, delim_v, mask_v, open_v, supp_v);
   endtask

   // one line with random content, mostly well formed
   task automatic send_random_line();
      int         len;
      int         r;
      logic [7:0] b;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30)
            b = sel_delim;
         else if (r < 70)
            b = 8'h61 + 8'($urandom_range(0, 3));
         else
            b = 8'($urandom_range(0, 255));
         send_item(b, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 80)
         send_item(NEWLINE_BYTE, 1'b0);
      else if (r < 92)
         send_item(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 19) == 0)
         send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_random_lines();
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         set_idling(idling_type'(phase / 2));
         random_configure();
         target = items_sent + 22;
         while (items_sent < target)
            send_random_line();
      end
   endtask

   // test sequence
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_MODE;
      csr_data     = '0;
      failures     = 0;
      items_sent   = 0;
      stall_cycles = 0;
      sel_mode     = MODE_BYTES;
      sel_delim    = TAB_BYTE;
      sel_mask     = '0;
      sel_open     = 16'd0;
      sel_suppress = 1'b0;
      clear_line_state();
      set_idling(IDLING_SENDER_LIGHT);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_byte_positions();
      test_field_join();
      test_newline_delimiter();
      test_suppressed_line();
      test_long_first_field();
      test_mode_change();
      test_random_lines();

      quiesce();
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/dfs_pkg.sv
rtl/core/dfs_store.sv
rtl/core/dfs_csr.sv
rtl/core/dfs_ctrl.sv
rtl/core/delimited_field_byte_selector.sv
rtl/core/dfs_checker.sv
test/testbench.sv
